@@ rtl/hidkb_pkg.sv @@
// Package for the boot-keyboard report decoder.
// Holds the key map tables, lane result type and shared constants.
package hidkb_pkg;

  localparam int KeySpace = 256;
  localparam int MapDepth = 100;
  localparam int GroupBits = 4;
  localparam int Groups = KeySpace / GroupBits;

  localparam logic [7:0] KEY_CTRL = 8'd133;
  localparam logic [7:0] KEY_SHIFT = 8'd134;
  localparam logic [7:0] KEY_ALT = 8'd132;
  localparam logic [7:0] KEY_GUI = 8'd156;
  localparam logic [7:0] ESC_LIMIT = 8'h7F;
  localparam logic [7:0] PFX_PRESS = 8'h7F;
  localparam logic [7:0] PFX_RELEASE = 8'hFF;
  localparam logic [7:0] RELEASE_BIT = 8'h80;

  typedef struct packed {
    logic       hit;
    logic [7:0] key;
  } lane_t;

  localparam logic [7:0] PLAIN_MAP [0:MapDepth-1] = '{
    8'h00,8'h00,8'h00,8'h00,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6A,
    8'h6B,8'h6C,8'h6D,8'h6E,8'h6F,8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,
    8'h79,8'h7A,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h30,8'h0D,8'h1B,
    8'h08,8'h09,8'h20,8'h2D,8'h3D,8'h5B,8'h5D,8'h5C,8'h00,8'h3B,8'h27,8'h60,8'h2C,8'h2E,
    8'h2F,8'h00,8'h87,8'h88,8'h89,8'h8A,8'h8B,8'h8C,8'h8D,8'h8E,8'h8F,8'h90,8'h91,8'h92,
    8'h00,8'h00,8'h99,8'h93,8'h97,8'h96,8'h7F,8'h98,8'h95,8'h83,8'h82,8'h81,8'h80,8'h00,
    8'hCF,8'hCE,8'hCD,8'hCC,8'hDA,8'hD1,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,8'hD7,8'hD8,8'hD9,
    8'hD0,8'hDB
  };

  localparam logic [7:0] SHIFT_MAP [0:MapDepth-1] = '{
    8'h00,8'h00,8'h00,8'h00,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,
    8'h4B,8'h4C,8'h4D,8'h4E,8'h4F,8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,
    8'h59,8'h5A,8'h21,8'h40,8'h23,8'h24,8'h25,8'h5E,8'h26,8'h2A,8'h28,8'h29,8'h0D,8'h1B,
    8'h08,8'h09,8'h20,8'h3C,8'h2B,8'h7B,8'h7D,8'h7C,8'h00,8'h3B,8'h22,8'h7E,8'h3C,8'h3E,
    8'h3F,8'h00,8'h87,8'h88,8'h89,8'h8A,8'h8B,8'h8C,8'h8D,8'h8E,8'h8F,8'h90,8'h91,8'h92,
    8'h00,8'h00,8'h99,8'h93,8'h97,8'h96,8'h7F,8'h98,8'h95,8'h83,8'h82,8'h81,8'h80,8'h00,
    8'hCF,8'hCE,8'hCD,8'hCC,8'hDA,8'hD1,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,8'hD7,8'hD8,8'hD9,
    8'hD0,8'hDB
  };

  function automatic logic [7:0] map_key(input logic [7:0] code, input logic shifted);
    logic [7:0] res;
    res = 8'h00;
    if (code < 8'(MapDepth)) begin
      res = shifted ? SHIFT_MAP[code[6:0]] : PLAIN_MAP[code[6:0]];
    end
    return res;
  endfunction

endpackage

@@ rtl/hidkb_lane.sv @@
// One key slot lane: maps a usage code to a key number.
// Depends on hidkb_pkg.
module hidkb_lane (
  input  logic [7:0]      code,
  input  logic            shifted,
  output hidkb_pkg::lane_t res
);
  import hidkb_pkg::*;

  always_comb begin
    res.hit = (code != 8'h00);
    res.key = map_key(code, shifted);
  end
endmodule

@@ rtl/hidkb_merge.sv @@
// Merge stage: builds the pressed mask from the lanes, diffs it against
// the stored mask and scans changed keys into event bytes. Uses hidkb_pkg.
module hidkb_merge #(
  parameter int Lanes = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [7:0]            mods,
  input  hidkb_pkg::lane_t      lanes [Lanes],
  output logic                  idle,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_last
);
  import hidkb_pkg::*;

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t              state_r, state_nxt;
  logic [KeySpace-1:0] prev_r, prev_nxt, diff_r, diff_nxt, now_mask, clr;
  logic [5:0]          ptr_r, ptr_nxt;
  logic                second_r, second_nxt;
  logic                ovalid_r, ovalid_nxt, olast_r, olast_nxt;
  logic [7:0]          obyte_r, obyte_nxt;
  logic [GroupBits-1:0] grp, held;
  logic [1:0]          sel;
  logic [7:0]          key;
  logic                can_load;

  always_comb begin
    now_mask = '0;
    for (int i = 0; i < Lanes; i++) begin
      if (lanes[i].hit) now_mask[lanes[i].key] = 1'b1;
    end
    if (mods[0]) now_mask[KEY_CTRL] = 1'b1;
    if (mods[1]) now_mask[KEY_SHIFT] = 1'b1;
    if (mods[2]) now_mask[KEY_ALT] = 1'b1;
    if (mods[3]) now_mask[KEY_GUI] = 1'b1;
  end

  always_comb begin
    grp  = diff_r[ptr_r*GroupBits +: GroupBits];
    held = prev_r[ptr_r*GroupBits +: GroupBits];
    sel  = grp[0] ? 2'd0 : grp[1] ? 2'd1 : grp[2] ? 2'd2 : 2'd3;
    key  = {ptr_r, sel};
    clr  = '0;
    clr[key] = 1'b1;
    can_load = !ovalid_r || out_ready;

    state_nxt  = state_r;
    prev_nxt   = prev_r;
    diff_nxt   = diff_r;
    ptr_nxt    = ptr_r;
    second_nxt = second_r;
    ovalid_nxt = ovalid_r && !out_ready;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          prev_nxt = now_mask;
          diff_nxt = (prev_r ^ now_mask) & ~(KeySpace'(1) << (KeySpace - 1));
          ptr_nxt  = '0;
          second_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (diff_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (grp == '0) begin
          ptr_nxt = ptr_r + 6'd1;
        end else if (can_load) begin
          ovalid_nxt = 1'b1;
          if (key >= ESC_LIMIT && !second_r) begin
            obyte_nxt  = held[sel] ? PFX_PRESS : PFX_RELEASE;
            olast_nxt  = 1'b0;
            second_nxt = 1'b1;
          end else begin
            if (key >= ESC_LIMIT) obyte_nxt = key;
            else obyte_nxt = held[sel] ? key : (key | RELEASE_BIT);
            second_nxt = 1'b0;
            diff_nxt   = diff_r & ~clr;
            olast_nxt  = ((diff_r & ~clr) == '0);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      prev_r   <= '0;
      diff_r   <= '0;
      ptr_r    <= '0;
      second_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      prev_r   <= prev_nxt;
      diff_r   <= diff_nxt;
      ptr_r    <= ptr_nxt;
      second_r <= second_nxt;
      ovalid_r <= ovalid_nxt;
    end
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign out_valid = ovalid_r;
  assign out_byte  = obyte_r;
  assign out_last  = olast_r;
endmodule

@@ rtl/hid_keyboard_report_to_key_events.sv @@
// Boot-keyboard report to key event byte stream.
// The scan walks up to 64 groups of 4 keys, one group step or one byte per cycle
// while the output is not stalled, and holds the input until the scan is done.
// One report in flight at a time.
// Reset clears the held-key mask (no key down) and empties the output.
module hid_keyboard_report_to_key_events #(
  parameter int KEY_SLOTS = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_modifier_bits,
  input  logic [7:0] in_key_slot0,
  input  logic [7:0] in_key_slot1,
  input  logic [7:0] in_key_slot2,
  input  logic [7:0] in_key_slot3,
  input  logic [7:0] in_key_slot4,
  input  logic [7:0] in_key_slot5,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_event_byte,
  output logic       out_last_event
);
  import hidkb_pkg::*;

  logic [7:0] slots [6];
  lane_t      lanes [KEY_SLOTS];
  logic       idle;

  assign slots[0] = in_key_slot0;
  assign slots[1] = in_key_slot1;
  assign slots[2] = in_key_slot2;
  assign slots[3] = in_key_slot3;
  assign slots[4] = in_key_slot4;
  assign slots[5] = in_key_slot5;

  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_lane
    hidkb_lane u_lane (
      .code    (slots[i]),
      .shifted (in_modifier_bits[1]),
      .res     (lanes[i])
    );
  end

  assign in_ready = idle;

  hidkb_merge #(.Lanes(KEY_SLOTS)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && idle),
    .mods      (in_modifier_bits),
    .lanes     (lanes),
    .idle      (idle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_event_byte),
    .out_last  (out_last_event)
  );
endmodule

@@ sim/tb_top.sv @@
// Testbench for hid_keyboard_report_to_key_events: drives keyboard reports,
// predicts event bytes from a held-key mask, checks the output stream.
// Depends on rtl/hidkb_pkg.sv and the decoder RTL.
`timescale 1ns / 100ps

class key_event_board;
  typedef struct {
    logic [7:0] ev;
    logic       last;
  } event_t;

  logic [255:0] held_keys;
  event_t       pending[$];
  int           errors;

  static const logic [7:0] PLAIN[0:99] = '{
    8'h00,8'h00,8'h00,8'h00,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6A,
    8'h6B,8'h6C,8'h6D,8'h6E,8'h6F,8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,
    8'h79,8'h7A,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h30,8'h0D,8'h1B,
    8'h08,8'h09,8'h20,8'h2D,8'h3D,8'h5B,8'h5D,8'h5C,8'h00,8'h3B,8'h27,8'h60,8'h2C,8'h2E,
    8'h2F,8'h00,8'h87,8'h88,8'h89,8'h8A,8'h8B,8'h8C,8'h8D,8'h8E,8'h8F,8'h90,8'h91,8'h92,
    8'h00,8'h00,8'h99,8'h93,8'h97,8'h96,8'h7F,8'h98,8'h95,8'h83,8'h82,8'h81,8'h80,8'h00,
    8'hCF,8'hCE,8'hCD,8'hCC,8'hDA,8'hD1,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,8'hD7,8'hD8,8'hD9,
    8'hD0,8'hDB};
  static const logic [7:0] SHIFTED[0:99] = '{
    8'h00,8'h00,8'h00,8'h00,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,
    8'h4B,8'h4C,8'h4D,8'h4E,8'h4F,8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,
    8'h59,8'h5A,8'h21,8'h40,8'h23,8'h24,8'h25,8'h5E,8'h26,8'h2A,8'h28,8'h29,8'h0D,8'h1B,
    8'h08,8'h09,8'h20,8'h3C,8'h2B,8'h7B,8'h7D,8'h7C,8'h00,8'h3B,8'h22,8'h7E,8'h3C,8'h3E,
    8'h3F,8'h00,8'h87,8'h88,8'h89,8'h8A,8'h8B,8'h8C,8'h8D,8'h8E,8'h8F,8'h90,8'h91,8'h92,
    8'h00,8'h00,8'h99,8'h93,8'h97,8'h96,8'h7F,8'h98,8'h95,8'h83,8'h82,8'h81,8'h80,8'h00,
    8'hCF,8'hCE,8'hCD,8'hCC,8'hDA,8'hD1,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,8'hD7,8'hD8,8'hD9,
    8'hD0,8'hDB};

  function new();
    held_keys = '0;
    errors = 0;
  endfunction

  function void push(logic [7:0] b);
    event_t e;
    e.ev = b;
    e.last = 1'b0;
    pending.push_back(e);
  endfunction

  function void note_request(logic [7:0] mods, logic [7:0] slots[6]);
    logic [255:0] now;
    logic [7:0]   key;
    int           start;
    now = '0;
    start = pending.size();
    foreach (slots[s]) begin
      if (slots[s] != 8'h00) begin
        key = 8'h00;
        if (slots[s] < 8'd100) key = mods[1] ? SHIFTED[slots[s]] : PLAIN[slots[s]];
        now[key] = 1'b1;
      end
    end
    if (mods[0]) now[hidkb_pkg::KEY_CTRL] = 1'b1;
    if (mods[1]) now[hidkb_pkg::KEY_SHIFT] = 1'b1;
    if (mods[2]) now[hidkb_pkg::KEY_ALT] = 1'b1;
    if (mods[3]) now[hidkb_pkg::KEY_GUI] = 1'b1;
    for (int k = 0; k < 255; k++) begin
      if (now[k] != held_keys[k]) begin
        if (k < 127) begin
          push(held_keys[k] ? (8'(k) | hidkb_pkg::RELEASE_BIT) : 8'(k));
        end else begin
          push(held_keys[k] ? hidkb_pkg::PFX_RELEASE : hidkb_pkg::PFX_PRESS);
          push(8'(k));
        end
      end
    end
    if (pending.size() > start) pending[pending.size()-1].last = 1'b1;
    held_keys = now;
  endfunction

  function void check_event(logic [7:0] ev, logic last);
    event_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected event byte %h last %b", $time, ev, last);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e.ev !== ev) begin
      $display("%0t: event_byte expected %h actual %h", $time, e.ev, ev);
      errors++;
    end
    if (e.last !== last) begin
      $display("%0t: last_event expected %b actual %b", $time, e.last, last);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_modifier_bits;
  logic [7:0] in_key_slot0, in_key_slot1, in_key_slot2;
  logic [7:0] in_key_slot3, in_key_slot4, in_key_slot5;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_event_byte;
  logic       out_last_event;

  key_event_board board;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off;
  longint cycles;

  hid_keyboard_report_to_key_events dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL hid_keyboard_report_to_key_events");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_event(out_event_byte, out_last_event);
    if (rst_n && in_valid && in_ready)
      board.note_request(in_modifier_bits, '{in_key_slot0, in_key_slot1, in_key_slot2,
                                             in_key_slot3, in_key_slot4, in_key_slot5});
  end

  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // leaves in_valid high after the accepting edge; the next call replaces the report or drops it, drain() drops it
  task automatic send_report(logic [7:0] m, logic [7:0] s0, logic [7:0] s1, logic [7:0] s2,
                             logic [7:0] s3, logic [7:0] s4, logic [7:0] s5);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_modifier_bits <= m;
    {in_key_slot0, in_key_slot1, in_key_slot2} <= {s0, s1, s2};
    {in_key_slot3, in_key_slot4, in_key_slot5} <= {s3, s4, s5};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(9))
      0: return 8'($urandom_range(255));
      1, 2: return 8'h00;
      default: return 8'($urandom_range(99));
    endcase
  endfunction

  task automatic random_report();
    logic [7:0] m;
    m = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
    send_report(m, pick_code(), pick_code(), pick_code(), pick_code(), pick_code(),
                pick_code());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    board = new();
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_modifier_bits = '0;
    {in_key_slot0, in_key_slot1, in_key_slot2} = '0;
    {in_key_slot3, in_key_slot4, in_key_slot5} = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty, extremes, modifiers, escapes, unmapped, duplicates
    send_report(8'h00, 0, 0, 0, 0, 0, 0);
    send_report(8'h0F, 8'h04, 8'h1D, 8'h27, 8'h3A, 8'h4C, 8'h63);
    send_report(8'h0F, 8'h04, 8'h1D, 8'h27, 8'h3A, 8'h4C, 8'h63);
    send_report(8'hF0, 8'hFF, 8'h80, 8'h64, 8'h01, 8'h32, 8'h39);
    send_report(8'h02, 8'h04, 8'h04, 8'h2D, 8'h36, 8'h1E, 8'h1F);
    send_report(8'h00, 8'h04, 8'h04, 8'h2D, 8'h36, 8'h1E, 8'h1F);
    send_report(8'hFF, 8'h59, 8'h5A, 8'h5B, 8'h5C, 8'h5D, 8'h62);
    send_report(8'h00, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F);
    send_report(8'h55, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h38);
    send_report(8'hAA, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45);
    send_report(8'h00, 0, 0, 0, 0, 0, 0);
    send_report(8'h01, 8'h7F, 0, 0, 0, 0, 0);
    send_report(8'h04, 0, 0, 0, 0, 0, 8'h51);
    send_report(8'h08, 0, 0, 0, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 66 : (ph == 3) ? 25 : 0;
      recv_stall_pct = (ph == 2) ? 66 : (ph == 3) ? 25 : 0;
      if (ph == 0) hold_off = 600;
      for (int i = 0; i < 62; i++) random_report();
      drain();
    end
    send_report(8'h00, 0, 0, 0, 0, 0, 0);
    drain();

    if (board.errors == 0) begin
      $display("PASS hid_keyboard_report_to_key_events");
    end else begin
      $display("FAIL hid_keyboard_report_to_key_events");
    end
    $finish;
  end
endmodule

@@ hid_keyboard_report_to_key_events.f @@
rtl/hidkb_pkg.sv
rtl/hidkb_lane.sv
rtl/hidkb_merge.sv
rtl/hid_keyboard_report_to_key_events.sv
sim/tb_top.sv
